[design/assert_macros.svh]
// Concurrent assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define FBC_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("assertion failed");
`define FBC_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) (prop)) \
		else $error("assertion failed");
`else
`define FBC_ASSERT(lbl, clk, rst_n, prop)
`define FBC_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

[design/fbc_pkg.sv]
package fbc_pkg;

	localparam int ROUND_COUNT_DEF = 8;
	localparam int HALF_W          = 32;
	localparam int BLK_W           = 64;
	localparam int KEY_W           = 64;
	localparam int ROT_F_L         = 9;
	localparam int ROT_F_K         = 11;
	localparam int KEY_STEP        = 3;

	typedef struct packed {
		logic              op;
		logic [HALF_W-1:0] r;
		logic [HALF_W-1:0] l;
	} blk_t;

	// low half of key rotated right by sh
	function automatic logic [HALF_W-1:0] key_slice(input logic [KEY_W-1:0] key,
		input logic [5:0] sh);
		logic [2*KEY_W-1:0] d;
		d = {key, key} >> sh;
		return d[HALF_W-1:0];
	endfunction

	function automatic logic [HALF_W-1:0] round_fn(input logic [HALF_W-1:0] k,
		input logic [HALF_W-1:0] l);
		logic [HALF_W-1:0] l_rot;
		logic [HALF_W-1:0] k_rot;
		l_rot = {l[HALF_W-1-ROT_F_L:0], l[HALF_W-1:HALF_W-ROT_F_L]};
		k_rot = {k[ROT_F_K-1:0], k[HALF_W-1:ROT_F_K]};
		return l_rot ^ ~(k_rot ^ l);
	endfunction

endpackage

[design/fbc_round_cell.sv]
module fbc_round_cell #(
	parameter int ROUND_COUNT = fbc_pkg::ROUND_COUNT_DEF,
	parameter int IDX         = 0
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [fbc_pkg::KEY_W-1:0] cipher_key,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  fbc_pkg::blk_t             in_blk,
	output logic                      out_valid,
	input  logic                      out_ready,
	output fbc_pkg::blk_t             out_blk
);

	localparam int  ENC_SH  = (IDX * fbc_pkg::KEY_STEP) % 64;
	localparam int  DEC_SH  = ((ROUND_COUNT - 1 - IDX) * fbc_pkg::KEY_STEP) % 64;
	localparam bit  IS_LAST = (IDX == ROUND_COUNT - 1);

	logic                       valid_q;
	fbc_pkg::blk_t              blk_q;
	logic [fbc_pkg::HALF_W-1:0] rk;
	logic [fbc_pkg::HALF_W-1:0] t;
	fbc_pkg::blk_t              nxt;

	assign in_ready = !valid_q || out_ready;

	always_comb begin
		rk = fbc_pkg::key_slice(cipher_key, in_blk.op ? 6'(DEC_SH) : 6'(ENC_SH));
		t  = in_blk.r ^ fbc_pkg::round_fn(rk, in_blk.l);
		nxt.op = in_blk.op;
		if (IS_LAST) begin
			nxt.l = in_blk.l;
			nxt.r = t;
		end else begin
			nxt.l = t;
			nxt.r = in_blk.l;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			blk_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_blk   = blk_q;

endmodule

[design/feistel_block_cipher_64.sv]
// Pipeline: one registered round cell per stage between input transfer and output valid.
// Throughput: one block per cycle; each cell stalls only when it and all cells after it are full.
// The last cell's register is the output register.
// Reset (arst_n low) empties all cells and clears cipher_key to zero.
`include "assert_macros.svh"

module feistel_block_cipher_64 #(
	parameter int ROUND_COUNT = fbc_pkg::ROUND_COUNT_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [fbc_pkg::KEY_W-1:0] cfg_wdata,     // cipher_key
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	input  logic [fbc_pkg::BLK_W-1:0] s_axis_tdata,  // data_block
	input  logic                      s_axis_tuser,  // operation
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	output logic [fbc_pkg::BLK_W-1:0] m_axis_tdata   // result_block
);

	logic [fbc_pkg::KEY_W-1:0] key_q;
	logic [ROUND_COUNT:0]      vld;
	logic [ROUND_COUNT:0]      rdy;
	fbc_pkg::blk_t             blk [ROUND_COUNT+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg_we) begin
			key_q <= cfg_wdata;
		end
	end

	assign vld[0]       = s_axis_tvalid;
	assign s_axis_tready = rdy[0];
	assign blk[0].op    = s_axis_tuser;
	assign blk[0].l     = s_axis_tdata[fbc_pkg::HALF_W-1:0];
	assign blk[0].r     = s_axis_tdata[fbc_pkg::BLK_W-1:fbc_pkg::HALF_W];

	for (genvar g = 0; g < ROUND_COUNT; g++) begin : g_cell
		fbc_round_cell #(
			.ROUND_COUNT(ROUND_COUNT),
			.IDX        (g)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cipher_key(key_q),
			.in_valid  (vld[g]),
			.in_ready  (rdy[g]),
			.in_blk    (blk[g]),
			.out_valid (vld[g+1]),
			.out_ready (rdy[g+1]),
			.out_blk   (blk[g+1])
		);
	end

	assign rdy[ROUND_COUNT] = m_axis_tready;
	assign m_axis_tvalid    = vld[ROUND_COUNT];
	assign m_axis_tdata     = {blk[ROUND_COUNT].r, blk[ROUND_COUNT].l};

	`FBC_ASSERT(a_enter_first_cell, clk, arst_n, (s_axis_tvalid && s_axis_tready) |=> vld[1])
	`FBC_ASSERT(a_stall_only_full, clk, arst_n, !s_axis_tready |-> (&vld[ROUND_COUNT:1]))
	`FBC_ASSERT(a_out_held, clk, arst_n, (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
	`FBC_ASSERT_ALWAYS(a_reset_empty, clk, !arst_n |-> ($countones(vld[ROUND_COUNT:1]) == 0))

endmodule
